// ----- rtl/gbr_pkg.sv -----
// Shared types and constants of the 3x3 Gaussian blur block.
package gbr_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int WT_W       = 16;
  localparam int WIDTH_W    = 13;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TAPS       = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EDGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CORNER = 3'd4;

  localparam logic [WIDTH_W-1:0]  RST_WIDTH         = 13'd3200;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT        = 16'd1800;
  localparam logic [WT_W-1:0]     RST_WEIGHT_CENTER = 16'd10430;
  localparam logic [WT_W-1:0]     RST_WEIGHT_EDGE   = 16'd6326;
  localparam logic [WT_W-1:0]     RST_WEIGHT_CORNER = 16'd3837;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [WT_W-1:0]     weight_center;
    logic [WT_W-1:0]     weight_edge;
    logic [WT_W-1:0]     weight_corner;
  } cfg_t;

  typedef struct packed {
    logic row_top;
    logic row_bot;
    logic col_left;
    logic col_right;
    logic last;
  } flags_t;

  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] win;
    flags_t                     flags;
  } win_item_t;

endpackage

// ----- rtl/gaussian_blur_3x3_rgb_top.sv -----
// Top level of the 3x3 Gaussian blur on an RGB pixel stream.
//
// Takes one RGB pixel per clock in raster order and returns one filtered
// pixel per clock in steady state while out_tready is high. Each pixel needs
// one read-modify-write of a combined two-row line store (one read and one
// write port), which fixes the rate at one pixel per cycle. A result appears
// once the pixel one row plus one column further on has been taken in, so
// after the frame send width+1 flush beats (in_tuser high) to drain it; the
// beat that carries out_tlast is the frame's last result. Inside the block a
// result spends five register stages from intake to out_tvalid. A four-entry
// queue separates the window builder from the filter pipeline, and in_tready
// drops only while that queue, counting the window about to enter it, is full.
// The line stores need no clearing after
// reset. Write the configuration registers only while no frame is in flight.
module gaussian_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,   // red_in, green_in, blue_in
  input  logic                             in_tuser,   // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // red_out, green_out, blue_out
  output logic                             out_tlast,  // frame_end
  input  logic                             cfg_we,
  input  logic [gbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gbr_pkg::*;

  cfg_t               cfg_r;
  logic               push, pop, pop_valid;
  win_item_t          push_item, pop_item;
  logic [FIFO_CW-1:0] fifo_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width         <= RST_WIDTH;
      cfg_r.height        <= RST_HEIGHT;
      cfg_r.weight_center <= RST_WEIGHT_CENTER;
      cfg_r.weight_edge   <= RST_WEIGHT_EDGE;
      cfg_r.weight_corner <= RST_WEIGHT_CORNER;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:         cfg_r.width         <= cfg_wdata[WIDTH_W-1:0];
        REG_HEIGHT:        cfg_r.height        <= cfg_wdata[HEIGHT_W-1:0];
        REG_WEIGHT_CENTER: cfg_r.weight_center <= cfg_wdata[WT_W-1:0];
        REG_WEIGHT_EDGE:   cfg_r.weight_edge   <= cfg_wdata[WT_W-1:0];
        REG_WEIGHT_CORNER: cfg_r.weight_corner <= cfg_wdata[WT_W-1:0];
        default: ;
      endcase
    end
  end

  gbr_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg       (cfg_r),
    .fifo_cnt  (fifo_cnt),
    .push      (push),
    .push_item (push_item)
  );

  gbr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .cnt       (fifo_cnt)
  );

  gbr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- rtl/gbr_front.sv -----
// Front end: pixel intake, position counters, line stores and 3x3 window.
module gbr_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [23:0]              in_tdata,   // red_in, green_in, blue_in
  input  logic                     in_tuser,   // action
  input  gbr_pkg::cfg_t            cfg,
  input  logic [gbr_pkg::FIFO_CW-1:0] fifo_cnt,
  output logic                     push,
  output gbr_pkg::win_item_t       push_item
);
  import gbr_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int EW_W  = CNT_W + 1;
  localparam int LW    = (EW_W > WIDTH_W) ? EW_W : WIDTH_W;
  localparam int ROW_W = HEIGHT_W + 1;

  logic [CNT_W-1:0]    in_col_r, out_col_r;
  logic [ROW_W-1:0]    in_row_r;
  logic [HEIGHT_W-1:0] out_row_r;

  logic                s1_valid_r, s1_emit_r, fwd_en_r;
  logic [CNT_W-1:0]    s1_addr_r;
  logic [PIX_W-1:0]    s1_pix_r;
  flags_t              s1_flags_r;
  logic [2*PIX_W-1:0]  rd_r, fwd_word_r;
  logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
  logic [TAPS-1:0][PIX_W-1:0] win_r, win_nxt;

  logic                in_fire;
  logic [LW-1:0]       wext;
  logic [EW_W-1:0]     ew, in_col_p1, out_col_p1;
  logic [HEIGHT_W-1:0] eh;
  logic [ROW_W-1:0]    out_row_p1;
  logic                emit, in_wrap, out_wrap, s0_last;
  flags_t              s0_flags;
  logic [PIX_W-1:0]    pix;
  logic [2*PIX_W-1:0]  word, wr_word;
  logic [FIFO_CW-1:0]  credit_used;

  assign credit_used = fifo_cnt + FIFO_CW'(s1_valid_r);
  assign in_tready   = credit_used < FIFO_CW'(FIFO_DEPTH);
  assign in_fire     = in_tvalid && in_tready;
  assign pix         = in_tuser ? '0 : in_tdata;

  always_comb begin
    wext = LW'(cfg.width);
    if (cfg.width == '0) begin
      ew = EW_W'(1);
    end else if (wext > LW'(MAX_WIDTH)) begin
      ew = EW_W'(MAX_WIDTH);
    end else begin
      ew = EW_W'(wext);
    end
    eh = (cfg.height == '0) ? HEIGHT_W'(1) : cfg.height;
  end

  always_comb begin
    in_col_p1  = {1'b0, in_col_r} + EW_W'(1);
    out_col_p1 = {1'b0, out_col_r} + EW_W'(1);
    out_row_p1 = {1'b0, out_row_r} + ROW_W'(1);
    in_wrap    = in_col_p1 >= ew;
    out_wrap   = out_col_p1 >= ew;
    emit       = (in_row_r >= ROW_W'(2)) || (in_row_r == ROW_W'(1) && in_col_r != '0);
    s0_flags.row_top   = out_row_r != '0;
    s0_flags.row_bot   = out_row_p1 < {1'b0, eh};
    s0_flags.col_left  = out_col_r != '0;
    s0_flags.col_right = out_col_p1 < ew;
    s0_flags.last      = (out_row_r == eh - HEIGHT_W'(1)) &&
                         ({1'b0, out_col_r} == ew - EW_W'(1));
    s0_last = emit && s0_flags.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      fwd_en_r   <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      if (in_fire) begin
        fwd_en_r <= s1_valid_r && (s1_addr_r == in_col_r);
        if (s0_last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else begin
          if (in_wrap) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + ROW_W'(1);
          end else begin
            in_col_r <= CNT_W'(in_col_p1);
          end
          if (emit) begin
            if (out_wrap) begin
              out_col_r <= '0;
              out_row_r <= out_row_r + HEIGHT_W'(1);
            end else begin
              out_col_r <= CNT_W'(out_col_p1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r  <= in_col_r;
      s1_pix_r   <= pix;
      s1_emit_r  <= emit;
      s1_flags_r <= s0_flags;
      fwd_word_r <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r <= line_mem[in_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      line_mem[s1_addr_r] <= wr_word;
    end
  end

  // word holds {upper, lower}; the lower row moves up, the new pixel goes below
  assign word    = fwd_en_r ? fwd_word_r : rd_r;
  assign wr_word = {word[PIX_W-1:0], s1_pix_r};

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = word[2*PIX_W-1:PIX_W];
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = word[PIX_W-1:0];
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  assign push            = s1_valid_r && s1_emit_r;
  assign push_item.win   = win_nxt;
  assign push_item.flags = s1_flags_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && s0_last) |=>
      (in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0))
    else $error("position counters not cleared after frame end");

endmodule

// ----- rtl/gbr_fifo.sv -----
// Short queue of filter windows between front end and back end.
module gbr_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  gbr_pkg::win_item_t          push_item,
  input  logic                        pop,
  output logic                        pop_valid,
  output gbr_pkg::win_item_t          pop_item,
  output logic [gbr_pkg::FIFO_CW-1:0] cnt
);
  import gbr_pkg::*;

  win_item_t          mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;

  assign pop_valid = cnt_r != '0;
  assign pop_item  = mem_r[rd_ptr_r];
  assign cnt       = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < FIFO_CW'(FIFO_DEPTH) || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue underflow");

endmodule

// ----- rtl/gbr_back.sv -----
// Back end: masked tap sums, weight multiplies, truncate and clamp, output register.
module gbr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  gbr_pkg::win_item_t pop_item,
  output logic               pop,
  input  gbr_pkg::cfg_t      cfg,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [23:0]        out_tdata,   // red_out, green_out, blue_out
  output logic               out_tlast    // frame_end
);
  import gbr_pkg::*;

  localparam int SUM_W  = CH_W + 2;
  localparam int PRD_W  = SUM_W + WT_W;
  localparam int CPRD_W = CH_W + WT_W;
  localparam int TOT_W  = PRD_W + 2;

  logic                         b1_v_r, b2_v_r, out_v_r;
  logic [2:0][SUM_W-1:0]        csum_r, esum_r, csum_nxt, esum_nxt;
  logic [2:0][CH_W-1:0]         ctr_r;
  logic [2:0][PRD_W-1:0]        pc_r, pe_r;
  logic [2:0][CPRD_W-1:0]       pm_r;
  logic                         b1_last_r, b2_last_r, out_last_r;
  logic [2:0][CH_W-1:0]         res_nxt, res_r;
  logic [TOT_W-1:0]             total;
  logic [TOT_W-WT_W-1:0]        trunc;
  logic                         o_ready, b2_ready, b1_ready;
  flags_t                       f;

  function automatic logic [SUM_W-1:0] tap(input logic [CH_W-1:0] px, input logic en);
    return en ? SUM_W'(px) : '0;
  endfunction

  assign o_ready  = !out_v_r || out_tready;
  assign b2_ready = !b2_v_r || o_ready;
  assign b1_ready = !b1_v_r || b2_ready;
  assign pop      = pop_valid && b1_ready;
  assign f        = pop_item.flags;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      csum_nxt[ch] = tap(pop_item.win[0][ch*CH_W +: CH_W], f.row_top && f.col_left)
                   + tap(pop_item.win[2][ch*CH_W +: CH_W], f.row_top && f.col_right)
                   + tap(pop_item.win[6][ch*CH_W +: CH_W], f.row_bot && f.col_left)
                   + tap(pop_item.win[8][ch*CH_W +: CH_W], f.row_bot && f.col_right);
      esum_nxt[ch] = tap(pop_item.win[1][ch*CH_W +: CH_W], f.row_top)
                   + tap(pop_item.win[3][ch*CH_W +: CH_W], f.col_left)
                   + tap(pop_item.win[5][ch*CH_W +: CH_W], f.col_right)
                   + tap(pop_item.win[7][ch*CH_W +: CH_W], f.row_bot);
    end
  end

  always_comb begin
    total = '0;
    trunc = '0;
    for (int ch = 0; ch < 3; ch++) begin
      total = TOT_W'(pc_r[ch]) + TOT_W'(pe_r[ch]) + TOT_W'(pm_r[ch]);
      trunc = total[TOT_W-1:WT_W];
      res_nxt[ch] = (trunc > (TOT_W-WT_W)'(CH_MAX)) ? CH_MAX : trunc[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (b1_ready) begin
        b1_v_r <= pop_valid;
      end
      if (b2_ready) begin
        b2_v_r <= b1_v_r;
      end
      if (o_ready) begin
        out_v_r <= b2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      csum_r    <= csum_nxt;
      esum_r    <= esum_nxt;
      for (int ch = 0; ch < 3; ch++) begin
        ctr_r[ch] <= pop_item.win[4][ch*CH_W +: CH_W];
      end
      b1_last_r <= f.last;
    end
    if (b1_v_r && b2_ready) begin
      for (int ch = 0; ch < 3; ch++) begin
        pc_r[ch] <= PRD_W'(csum_r[ch]) * PRD_W'(cfg.weight_corner);
        pe_r[ch] <= PRD_W'(esum_r[ch]) * PRD_W'(cfg.weight_edge);
        pm_r[ch] <= CPRD_W'(ctr_r[ch]) * CPRD_W'(cfg.weight_center);
      end
      b2_last_r <= b1_last_r;
    end
    if (b2_v_r && o_ready) begin
      res_r      <= res_nxt;
      out_last_r <= b2_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = res_r;
  assign out_tlast  = out_last_r;

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_v_r && !b2_ready) |=> b1_v_r)
    else $error("sum stage lost an item while stalled");

endmodule

// ----- tb/gaussian_blur_3x3_rgb_top_tb.sv -----
// Self-checking testbench: streams RGB frames through the 3x3 blur and checks each beat.
`timescale 1ns / 1ps

module gaussian_blur_3x3_rgb_top_tb;
  import gbr_pkg::*;

  localparam int LINE_DEPTH   = 4096;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_BEATS  = 550;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic [PIX_W-1:0] WHITE = 24'hFFFFFF;
  localparam logic [PIX_W-1:0] BLACK = 24'h000000;

  typedef struct packed {
    logic [PIX_W-1:0] rgb;  // red [7:0], green [15:8], blue [23:16]
    logic             frame_end;
  } blur_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  act;
    logic [PIX_W-1:0]      pix;
    logic                  typed;
    blur_t                 want;
  } tv_row_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata   = '0;  // red_in, green_in, blue_in
  logic                  in_tuser   = 1'b0;  // action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;  // red_out, green_out, blue_out
  logic                  out_tlast;  // frame_end
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  gaussian_blur_3x3_rgb_top #(
    .MAX_WIDTH(LINE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [WIDTH_W-1:0]  cfg_w;
  logic [HEIGHT_W-1:0] cfg_h;
  logic [WT_W-1:0]     wt_center, wt_edge, wt_corner;
  logic [PIX_W-1:0]    upper_row [LINE_DEPTH];
  logic [PIX_W-1:0]    lower_row [LINE_DEPTH];
  logic [PIX_W-1:0]    win [TAPS];
  int unsigned         in_col, in_row, out_col, out_row;

  blur_t       blur_queue [$];
  blur_t       head_blur;
  tv_row_t     directed_rows [$];
  string       chan_name [3] = '{"red", "green", "blue"};
  int          send_idle = 20;
  int          recv_idle = 45;
  int unsigned mismatches = 0;
  int unsigned pixels_checked = 0;
  int unsigned beats_sent = 0;
  int unsigned frames_run = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_w();
    if (cfg_w == 0) return 1;
    if (cfg_w > LINE_DEPTH) return LINE_DEPTH;
    return cfg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (cfg_h == 0) ? 1 : cfg_h;
  endfunction

  function automatic void blur_reset();
    cfg_w     = RST_WIDTH;
    cfg_h     = RST_HEIGHT;
    wt_center = RST_WEIGHT_CENTER;
    wt_edge   = RST_WEIGHT_EDGE;
    wt_corner = RST_WEIGHT_CORNER;
    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic void blur_step(input logic act, input logic [PIX_W-1:0] pix_in,
                                    output bit emit, output blur_t res);
    logic [PIX_W-1:0] pix, top, mid;
    int unsigned      ew, eh, addr, acc, wt;
    bit               rowok [3];
    bit               colok [3];
    ew   = eff_w();
    eh   = eff_h();
    pix  = (act == ACT_PIXEL) ? pix_in : BLACK;
    addr = (in_col < LINE_DEPTH) ? in_col : LINE_DEPTH - 1;
    top  = upper_row[addr];
    mid  = lower_row[addr];
    upper_row[addr] = mid;
    lower_row[addr] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= ew) begin
      in_col = 0;
      in_row = (in_row + 1) & 32'h1FFFF;
    end else begin
      in_col++;
    end
    res = '0;
    if (!emit) return;
    rowok = '{out_row > 0, 1'b1, out_row + 1 < eh};
    colok = '{out_col > 0, 1'b1, out_col + 1 < ew};
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (rowok[r] && colok[c]) begin
            if (r == 1 && c == 1) wt = wt_center;
            else if (r == 1 || c == 1) wt = wt_edge;
            else wt = wt_corner;
            acc += wt * win[r*3+c][8*ch +: 8];
          end
        end
      end
      acc = acc >> 16;
      res.rgb[8*ch +: 8] = (acc > CH_MAX) ? CH_MAX : acc[7:0];
    end
    res.frame_end = (out_row == eh - 1) && (out_col == ew - 1);
    if (res.frame_end) begin
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    end else if (out_col + 1 >= ew) begin
      out_col = 0;
      out_row = (out_row + 1) & 32'hFFFF;
    end else begin
      out_col++;
    end
  endfunction

  function automatic tv_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_row        = '0;
    cfg_row.is_cfg = 1'b1;
    cfg_row.idx    = idx;
    cfg_row.val    = val;
  endfunction

  function automatic tv_row_t beat_row(logic act, logic [PIX_W-1:0] pix);
    beat_row     = '0;
    beat_row.act = act;
    beat_row.pix = pix;
  endfunction

  function automatic tv_row_t checked_row(logic act, logic [PIX_W-1:0] pix,
                                          logic [PIX_W-1:0] rgb, logic fe);
    checked_row       = beat_row(act, pix);
    checked_row.typed = 1'b1;
    checked_row.want  = '{rgb, fe};
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] rand_pix();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  function automatic logic [WT_W-1:0] pick_weight(int unsigned style);
    case (style)
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(8191));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  task automatic report_error(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_WIDTH:         cfg_w = val[WIDTH_W-1:0];
      REG_HEIGHT:        cfg_h = val[HEIGHT_W-1:0];
      REG_WEIGHT_CENTER: wt_center = val[WT_W-1:0];
      REG_WEIGHT_EDGE:   wt_edge = val[WT_W-1:0];
      REG_WEIGHT_CORNER: wt_corner = val[WT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_idle();
    in_tvalid <= 1'b0;
    while (blur_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_beat(input logic act, input logic [PIX_W-1:0] pix,
                           input logic typed, input blur_t typed_res);
    bit    emit;
    blur_t res;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    blur_step(act, pix, emit, res);
    if (emit) blur_queue.push_back(typed ? typed_res : res);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic run_frame(input logic [CFG_DATA_W-1:0] w_val, input logic [CFG_DATA_W-1:0] h_val);
    int unsigned style, n_pix, ew;
    drain_idle();
    style = $urandom_range(2);
    write_reg(REG_WIDTH, w_val);
    write_reg(REG_HEIGHT, h_val);
    write_reg(REG_WEIGHT_CENTER, pick_weight(style));
    write_reg(REG_WEIGHT_EDGE, pick_weight(style));
    write_reg(REG_WEIGHT_CORNER, pick_weight(style));
    ew    = eff_w();
    n_pix = ew * eff_h();
    for (int unsigned i = 0; i < n_pix; i++)
      send_beat(($urandom_range(99) < 8) ? ACT_FLUSH : ACT_PIXEL, rand_pix(), 1'b0, '0);
    for (int unsigned i = 0; i <= ew; i++)
      send_beat(($urandom_range(99) < 80) ? ACT_FLUSH : ACT_PIXEL, rand_pix(), 1'b0, '0);
    frames_run++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return 16'd0;
    if (r < 12) return 16'd1;
    return 16'($urandom_range(9, 2));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_height();
    return ($urandom_range(99) < 6) ? 16'd0 : 16'($urandom_range(4, 1));
  endfunction

  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, blur_queue.size());
      $display("gaussian_blur_3x3_rgb_top_tb: done, errors");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      if (blur_queue.size() == 0) begin
        report_error($sformatf("unexpected beat tdata=%h tlast=%b", out_tdata, out_tlast));
      end else begin
        head_blur = blur_queue.pop_front();
        for (int ch = 0; ch < 3; ch++)
          if (out_tdata[8*ch +: 8] !== head_blur.rgb[8*ch +: 8])
            report_error($sformatf("pixel %0d %s got %0d want %0d", pixels_checked,
                         chan_name[ch], out_tdata[8*ch +: 8], head_blur.rgb[8*ch +: 8]));
        if (out_tlast !== head_blur.frame_end)
          report_error($sformatf("pixel %0d frame_end got %b want %b", pixels_checked,
                       out_tlast, head_blur.frame_end));
        pixels_checked++;
      end
    end
  end

  initial begin
    int unsigned phase_start;
    blur_reset();
    directed_rows = '{
      cfg_row(REG_WIDTH, 16'd1),
      cfg_row(REG_HEIGHT, 16'd1),
      beat_row(ACT_PIXEL, WHITE),
      beat_row(ACT_FLUSH, BLACK),
      checked_row(ACT_FLUSH, BLACK, 24'h282828, 1'b1),
      cfg_row(REG_WEIGHT_CENTER, 16'hFFFF),
      cfg_row(REG_WEIGHT_EDGE, 16'hFFFF),
      cfg_row(REG_WEIGHT_CORNER, 16'hFFFF),
      cfg_row(REG_WIDTH, 16'd0),
      cfg_row(REG_HEIGHT, 16'd0),
      beat_row(ACT_PIXEL, 24'h0100FF),
      beat_row(ACT_FLUSH, WHITE),
      checked_row(ACT_FLUSH, BLACK, 24'h0000FE, 1'b1),
      cfg_row(REG_WIDTH, 16'd2),
      cfg_row(REG_HEIGHT, 16'd2),
      beat_row(ACT_PIXEL, WHITE),
      beat_row(ACT_PIXEL, WHITE),
      beat_row(ACT_PIXEL, WHITE),
      checked_row(ACT_PIXEL, WHITE, WHITE, 1'b0),
      checked_row(ACT_FLUSH, BLACK, WHITE, 1'b0),
      checked_row(ACT_FLUSH, BLACK, WHITE, 1'b0),
      checked_row(ACT_FLUSH, BLACK, WHITE, 1'b1),
      cfg_row(REG_WEIGHT_CENTER, 16'd0),
      cfg_row(REG_WEIGHT_EDGE, 16'd0),
      cfg_row(REG_WEIGHT_CORNER, 16'd0),
      cfg_row(REG_HEIGHT, 16'd1),
      beat_row(ACT_PIXEL, WHITE),
      beat_row(ACT_PIXEL, WHITE),
      beat_row(ACT_FLUSH, BLACK),
      checked_row(ACT_FLUSH, BLACK, BLACK, 1'b0),
      checked_row(ACT_FLUSH, BLACK, BLACK, 1'b1),
      cfg_row(REG_WEIGHT_CENTER, RST_WEIGHT_CENTER),
      cfg_row(REG_WEIGHT_EDGE, RST_WEIGHT_EDGE),
      cfg_row(REG_WEIGHT_CORNER, RST_WEIGHT_CORNER),
      cfg_row(REG_HEIGHT, 16'd2),
      beat_row(ACT_PIXEL, 24'h4DC80C),
      beat_row(ACT_FLUSH, WHITE),
      beat_row(ACT_PIXEL, 24'h0180FF),
      beat_row(ACT_PIXEL, 24'hFF0000),
      beat_row(ACT_FLUSH, BLACK),
      beat_row(ACT_PIXEL, 24'h090909),
      beat_row(ACT_FLUSH, 24'h123456)
    };
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_beat(directed_rows[i].act, directed_rows[i].pix,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end
    frames_run += 5;

    for (int mode = 0; mode < 3; mode++) begin
      send_idle   = (mode == 0) ? 20 : (mode == 1) ? 45 : 0;
      recv_idle   = (mode == 0) ? 45 : (mode == 1) ? 20 : 0;
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS) run_frame(rand_width(), rand_height());
    end
    drain_idle();

    $display("covered %0d frames, %0d input beats, %0d filtered pixels compared",
             frames_run, beats_sent, pixels_checked);
    $display("widths 0 to 9, heights 0 to 4, weights 0 to 65535, three stall mixes");
    if (mismatches == 0) begin
      $display("gaussian_blur_3x3_rgb_top_tb: done, clean");
    end else begin
      $display("gaussian_blur_3x3_rgb_top_tb: done, errors");
    end
    $finish;
  end

endmodule
